// ===== rtl/pareto_pool_with_roulette_pick_unit_assert.svh =====
// Assertion macros for the Pareto pool unit.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef PARETO_POOL_WITH_ROULETTE_PICK_UNIT_ASSERT_SVH
`define PARETO_POOL_WITH_ROULETTE_PICK_UNIT_ASSERT_SVH

// Condition holds at every edge out of reset.
`define PPR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pool invariant violated");

// Antecedent implies consequent in the next cycle.
`define PPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pool sequencing violated");

// Antecedent implies consequent in the same cycle.
`define PPR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pool control violated");

`endif

// ===== rtl/ppr_pkg.sv =====
// Shared types and constants for the Pareto pool unit.
// No dependencies.
`default_nettype none
package ppr_pkg;

  localparam int DIV_W      = 64;
  localparam int HALF_SHIFT = 32;
  localparam int LIMIT_W    = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // field widths of tags and of scores and costs
  localparam int TAG_BITS   = 16;
  localparam int SCORE_BITS = 48;

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // status codes
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_CLEARED  = 3'd2;
  localparam logic [2:0] ST_SAMPLED  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [TAG_BITS-1:0]   entry_tag;
    logic [SCORE_BITS-1:0] entry_score;
    logic [SCORE_BITS-1:0] entry_cost;
    logic [63:0]           random_value;
  } item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [TAG_BITS-1:0]   picked_tag;
    logic [SCORE_BITS-1:0] picked_score;
    logic [TAG_BITS-1:0]   best_tag;
    logic [SCORE_BITS-1:0] best_score;
    logic [SCORE_BITS-1:0] best_cost;
    logic [6:0]            pool_count;
  } result_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/ppr_divmod.sv =====
// Bit-serial restoring modulo unit, one quotient bit per cycle.
// Depends on ppr_pkg for the request and response structs.
`default_nettype none
module ppr_divmod (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ppr_pkg::div_req_t req,
  output ppr_pkg::div_rsp_t      rsp
);

  localparam int W  = ppr_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] steps;
  logic [W-1:0]  dvd;
  logic [W-1:0]  dsr;
  logic [W:0]    rem;
  logic          done;
  logic [W:0]    rem_sh;
  logic          fits;

  // shift in next dividend bit and trial subtract
  assign rem_sh = {rem[W-1:0], dvd[W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= CW'(W);
        dvd   <= req.dividend;
        dsr   <= req.divisor;
        rem   <= '0;
      end else if (busy) begin
        rem   <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
        dvd   <= {dvd[W-2:0], 1'b0};
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem[W-1:0];

endmodule
`default_nettype wire

// ===== rtl/pareto_pool_with_roulette_pick_unit.sv =====
// Pareto pool with roulette pick: one item at a time, one pool entry per cycle.
// Result registered after an insert, clear or sample is processed; a sample runs a 64-step serial
// modulo. The single memory read port sets the pace. The next item can be taken in the cycle after
// the result is loaded. Reset: count 0, limit 64, entries undefined.
`default_nettype none
module pareto_pool_with_roulette_pick_unit #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire ppr_pkg::item_t                 item,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output ppr_pkg::result_t                    result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ppr_pkg::LIMIT_W-1:0]    cfg_data
);

  localparam int IW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int NW    = CNT_W + 1;
  localparam int LW    = (CNT_W > ppr_pkg::LIMIT_W) ? CNT_W : ppr_pkg::LIMIT_W;

  typedef struct packed {
    logic [ppr_pkg::TAG_BITS-1:0]   tag;
    logic [ppr_pkg::SCORE_BITS-1:0] score;
    logic [ppr_pkg::SCORE_BITS-1:0] cost;
  } slot_t;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_REJ  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_MOVE = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_WALK = 4'd6;
  localparam logic [3:0] S_PICK = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // pool storage
  slot_t mem [POOL_DEPTH];
  slot_t rdata;
  logic  we;
  logic [IW-1:0] waddr;
  slot_t wdata;

  // control and working registers
  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] wp, wp_next;
  logic [ppr_pkg::LIMIT_W-1:0] pool_limit;
  slot_t            cand, cand_next;
  slot_t            held, held_next;
  slot_t            best, best_next;
  logic [63:0]      rnd, rnd_next;
  logic [63:0]      acc, acc_next;
  logic             zero_tot, zero_tot_next;
  logic [2:0]       status, status_next;
  logic [ppr_pkg::TAG_BITS-1:0]   ptag, ptag_next;
  logic [ppr_pkg::SCORE_BITS-1:0] pscore, pscore_next;
  logic             result_load;
  logic [CNT_W-1:0] eff_lim;
  logic [LW-1:0]    lim_ext;
  logic [NW-1:0]    n_fin;
  logic             accept;
  logic             k_in;

  ppr_pkg::div_req_t div_req;
  ppr_pkg::div_rsp_t div_rsp;

  ppr_divmod u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[k_next[IW-1:0]];
  end

  // effective limit, clamped to 1..POOL_DEPTH
  assign lim_ext = LW'(pool_limit);
  always_comb begin
    if (pool_limit == '0) begin
      eff_lim = CNT_W'(1);
    end else if (lim_ext > LW'(POOL_DEPTH)) begin
      eff_lim = CNT_W'(POOL_DEPTH);
    end else begin
      eff_lim = CNT_W'(lim_ext);
    end
  end

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign k_in       = (k < cnt);
  assign n_fin      = NW'(wp) + NW'(1);

  // sequencer
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    k_next        = k;
    wp_next       = wp;
    cand_next     = cand;
    held_next     = held;
    best_next     = best;
    rnd_next      = rnd;
    acc_next      = acc;
    zero_tot_next = zero_tot;
    status_next   = status;
    ptag_next     = ptag;
    pscore_next   = pscore;
    we            = 1'b0;
    waddr         = wp[IW-1:0];
    wdata         = held;
    div_req       = '0;
    result_load   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cand_next.tag   = item.entry_tag;
          cand_next.score = item.entry_score;
          cand_next.cost  = item.entry_cost;
          rnd_next        = item.random_value;
          ptag_next       = '0;
          pscore_next     = '0;
          acc_next        = '0;
          k_next          = '0;
          unique case (item.opcode)
            ppr_pkg::OP_INSERT: begin
              if (cnt >= eff_lim && cnt != '0) begin
                k_next     = cnt - 1'b1;
                state_next = S_REJ;
              end else begin
                state_next = S_SCAN;
              end
            end
            ppr_pkg::OP_CLEAR: begin
              cnt_next    = '0;
              status_next = ppr_pkg::ST_CLEARED;
              state_next  = S_DONE;
            end
            ppr_pkg::OP_SAMPLE: begin
              if (cnt == '0) begin
                status_next = ppr_pkg::ST_EMPTY;
                state_next  = S_DONE;
              end else begin
                state_next = S_SUM;
              end
            end
            default: begin
              status_next = ppr_pkg::ST_REJECTED;
              state_next  = S_DONE;
            end
          endcase
        end
      end

      // full pool: candidate score must not be below the last entry's
      S_REJ: begin
        if (cand.score < rdata.score) begin
          status_next = ppr_pkg::ST_REJECTED;
          state_next  = S_DONE;
        end else begin
          k_next     = '0;
          state_next = S_SCAN;
        end
      end

      // walk higher-scoring entries looking for a dominator
      S_SCAN: begin
        if (k_in && rdata.score > cand.score) begin
          if (rdata.cost <= cand.cost) begin
            status_next = ppr_pkg::ST_REJECTED;
            state_next  = S_DONE;
          end else begin
            k_next = k + 1'b1;
          end
        end else begin
          wp_next    = k;
          held_next  = cand;
          state_next = S_MOVE;
          if (k_in && rdata.score == cand.score) begin
            k_next = k + 1'b1;
          end
        end
      end

      // compact the tail, keeping entries cheaper than the candidate
      S_MOVE: begin
        if (k_in) begin
          if (rdata.cost < cand.cost) begin
            we        = 1'b1;
            wp_next   = wp + 1'b1;
            held_next = rdata;
          end
          k_next = k + 1'b1;
        end else begin
          we = (NW'(wp) < NW'(POOL_DEPTH));
          if (n_fin > NW'(eff_lim)) begin
            cnt_next = CNT_W'(n_fin - NW'(1));
          end else begin
            cnt_next = CNT_W'(n_fin);
          end
          status_next = ppr_pkg::ST_STORED;
          state_next  = S_DONE;
        end
        if (we && wp == '0) begin
          best_next = held;
        end
      end

      // total of scores, then launch the modulo
      S_SUM: begin
        if (k_in) begin
          acc_next = acc + 64'(rdata.score);
          k_next   = k + 1'b1;
        end else begin
          div_req.start = 1'b1;
          zero_tot_next = (acc == '0);
          if (acc == '0) begin
            div_req.dividend = rnd >> ppr_pkg::HALF_SHIFT;
            div_req.divisor  = 64'(cnt);
          end else begin
            div_req.dividend = rnd;
            div_req.divisor  = acc;
          end
          state_next = S_DIV;
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          if (zero_tot) begin
            k_next     = CNT_W'(div_rsp.remainder);
            state_next = S_PICK;
          end else begin
            acc_next   = div_rsp.remainder;
            k_next     = '0;
            state_next = S_WALK;
          end
        end
      end

      // roulette walk over running sums
      S_WALK: begin
        if (acc < 64'(rdata.score) || k == cnt - 1'b1) begin
          ptag_next   = rdata.tag;
          pscore_next = rdata.score;
          status_next = ppr_pkg::ST_SAMPLED;
          state_next  = S_DONE;
        end else begin
          acc_next = acc - 64'(rdata.score);
          k_next   = k + 1'b1;
        end
      end

      S_PICK: begin
        ptag_next   = rdata.tag;
        pscore_next = rdata.score;
        status_next = ppr_pkg::ST_SAMPLED;
        state_next  = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      pool_limit   <= ppr_pkg::LIMIT_RESET;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_valid && cfg_ready) begin
        pool_limit <= cfg_data;
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k        <= k_next;
    wp       <= wp_next;
    cand     <= cand_next;
    held     <= held_next;
    best     <= best_next;
    rnd      <= rnd_next;
    acc      <= acc_next;
    zero_tot <= zero_tot_next;
    status   <= status_next;
    ptag     <= ptag_next;
    pscore   <= pscore_next;
    if (result_load) begin
      result.status       <= status;
      result.picked_tag   <= ptag;
      result.picked_score <= pscore;
      result.pool_count   <= 7'(cnt);
      if (cnt == '0) begin
        result.best_tag   <= '0;
        result.best_score <= '0;
        result.best_cost  <= '0;
      end else begin
        result.best_tag   <= best.tag;
        result.best_score <= best.score;
        result.best_cost  <= best.cost;
      end
    end
  end

`include "pareto_pool_with_roulette_pick_unit_assert.svh"

  `PPR_ASSERT_ALWAYS(a_cnt_bound, cnt <= CNT_W'(POOL_DEPTH))
  `PPR_ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE)
  `PPR_ASSERT_IMPL(a_div_done_wait, div_rsp.done, state == S_DIV)
  `PPR_ASSERT_IMPL(a_write_in_move, we, state == S_MOVE)

endmodule
`default_nettype wire

// ===== test/tb_pareto_pool_with_roulette_pick_unit.sv =====
// Testbench for the Pareto pool unit: directed table, then random inserts, clears, samples, unknown opcodes.
// Each result is checked against a behavioral pool model kept here; depends on ppr_pkg.
`default_nettype none
module tb_pareto_pool_with_roulette_pick_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 20000;
  // opcode with no meaning, takes the reject path
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  ppr_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ppr_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ppr_pkg::LIMIT_W-1:0] cfg_data = '0;

  pareto_pool_with_roulette_pick_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pool model state
  logic [15:0] pool_tag [DEPTH];
  logic [47:0] pool_score [DEPTH];
  logic [47:0] pool_cost [DEPTH];
  int pool_n;
  logic [6:0] limit_reg;

  ppr_pkg::result_t expected_q[$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  function automatic int eff_limit();
    int lim;
    lim = limit_reg;
    if (lim == 0) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    return lim;
  endfunction

  function automatic logic [2:0] pool_insert(logic [15:0] t, logic [47:0] s, logic [47:0] c);
    logic [15:0] nt [DEPTH+1];
    logic [47:0] ns [DEPTH+1];
    logic [47:0] nc [DEPTH+1];
    int i, j, n, lim;
    lim = eff_limit();
    i = 0;
    if (pool_n >= lim && pool_n > 0 && s < pool_score[pool_n-1])
      return ppr_pkg::ST_REJECTED;
    while (i < pool_n && pool_score[i] > s) begin
      if (pool_cost[i] <= c) return ppr_pkg::ST_REJECTED;
      i++;
    end
    for (j = 0; j < i; j++) begin
      nt[j] = pool_tag[j]; ns[j] = pool_score[j]; nc[j] = pool_cost[j];
    end
    n = i;
    nt[n] = t; ns[n] = s; nc[n] = c;
    n++;
    j = (i < pool_n && pool_score[i] == s) ? i + 1 : i;
    for (; j < pool_n; j++) begin
      if (pool_cost[j] < c) begin
        nt[n] = pool_tag[j]; ns[n] = pool_score[j]; nc[n] = pool_cost[j];
        n++;
      end
    end
    if (n > lim) n--;
    if (n > DEPTH) n = DEPTH;
    for (j = 0; j < n; j++) begin
      pool_tag[j] = nt[j]; pool_score[j] = ns[j]; pool_cost[j] = nc[j];
    end
    pool_n = n;
    return ppr_pkg::ST_STORED;
  endfunction

  function automatic int roulette_index(logic [63:0] rnd);
    logic [63:0] total, p;
    int k;
    total = '0;
    for (k = 0; k < pool_n; k++) total += 64'(pool_score[k]);
    if (total == 0) return int'((rnd >> ppr_pkg::HALF_SHIFT) % 64'(pool_n));
    p = rnd % total;
    for (k = 0; k < pool_n; k++) begin
      if (p < 64'(pool_score[k])) return k;
      p -= 64'(pool_score[k]);
    end
    return pool_n - 1;
  endfunction

  function automatic ppr_pkg::result_t pool_step(ppr_pkg::item_t it);
    ppr_pkg::result_t r;
    int k;
    r = '0;
    r.status = ppr_pkg::ST_REJECTED;
    case (it.opcode)
      ppr_pkg::OP_INSERT: r.status = pool_insert(it.entry_tag, it.entry_score, it.entry_cost);
      ppr_pkg::OP_CLEAR: begin
        pool_n = 0;
        r.status = ppr_pkg::ST_CLEARED;
      end
      ppr_pkg::OP_SAMPLE: begin
        if (pool_n == 0) begin
          r.status = ppr_pkg::ST_EMPTY;
        end else begin
          k = roulette_index(it.random_value);
          r.picked_tag = pool_tag[k];
          r.picked_score = pool_score[k];
          r.status = ppr_pkg::ST_SAMPLED;
        end
      end
      default: ;
    endcase
    if (pool_n > 0) begin
      r.best_tag = pool_tag[0];
      r.best_score = pool_score[0];
      r.best_cost = pool_cost[0];
    end
    r.pool_count = 7'(pool_n);
    return r;
  endfunction

  // receiver: stall pattern and result check
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          if (result !== expected_q[0]) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", expected_q[0], result);
          end
          void'(expected_q.pop_front());
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("pareto_pool_with_roulette_pick_unit verification failed");
      $finish;
    end
  end

  // valid stays high between back-to-back transfers, drops only while idling
  task automatic send_item(ppr_pkg::item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_q.push_back(pool_step(it));
  endtask

  // wait for every result, then write the limit register
  task automatic write_limit(logic [6:0] v);
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  function automatic ppr_pkg::item_t random_item(int score_span);
    ppr_pkg::item_t it;
    int sel;
    it.entry_tag = 16'($urandom);
    it.random_value = {$urandom, $urandom};
    sel = $urandom_range(99);
    it.opcode = sel < 62 ? ppr_pkg::OP_INSERT :
                (sel < 67 ? ppr_pkg::OP_CLEAR : (sel < 98 ? ppr_pkg::OP_SAMPLE : OP_UNKNOWN));
    case ($urandom_range(9))
      0: begin
        it.entry_score = 48'({$urandom, $urandom});
        it.entry_cost = 48'({$urandom, $urandom});
      end
      1: begin
        it.entry_score = '0;
        it.entry_cost = 48'($urandom_range(50));
      end
      default: begin
        // small spread builds deep fronts: cost falls as score falls
        it.entry_score = 48'($urandom_range(score_span));
        it.entry_cost = it.entry_score + 48'($urandom_range(8)) - 48'(4);
      end
    endcase
    return it;
  endfunction

  typedef struct {
    ppr_pkg::item_t it;
    logic check_now;
    ppr_pkg::result_t want;
  } vector_t;

  localparam logic [47:0] SMAX = '1;

  initial begin
    vector_t vec [];
    logic [6:0] limits [6];
    int phase, idx;
    mismatches = 0;
    quiet_cycles = 0;
    pool_n = 0;
    limit_reg = ppr_pkg::LIMIT_RESET;
    send_idle_pct = 8;
    recv_idle_pct = 68;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; want fields only where obvious
    vec = new[16];
    vec[0] = '{'{ppr_pkg::OP_SAMPLE, 16'h0, 48'h0, 48'h0, 64'h0}, 1'b1,
               '{ppr_pkg::ST_EMPTY, 16'h0, 48'h0, 16'h0, 48'h0, 48'h0, 7'd0}};
    vec[1] = '{'{OP_UNKNOWN, 16'hFFFF, SMAX, SMAX, '1}, 1'b1,
               '{ppr_pkg::ST_REJECTED, 16'h0, 48'h0, 16'h0, 48'h0, 48'h0, 7'd0}};
    vec[2] = '{'{ppr_pkg::OP_INSERT, 16'hFFFF, SMAX, SMAX, '1}, 1'b1,
               '{ppr_pkg::ST_STORED, 16'h0, 48'h0, 16'hFFFF, SMAX, SMAX, 7'd1}};
    vec[3] = '{'{ppr_pkg::OP_INSERT, 16'h0001, 48'd5, SMAX, 64'h0}, 1'b1,
               '{ppr_pkg::ST_REJECTED, 16'h0, 48'h0, 16'hFFFF, SMAX, SMAX, 7'd1}};
    vec[4] = '{'{ppr_pkg::OP_INSERT, 16'h0002, 48'd5, 48'd3, 64'h0}, 1'b0, '0};
    vec[5] = '{'{ppr_pkg::OP_INSERT, 16'h0003, 48'd5, 48'd1, 64'h0}, 1'b0, '0};
    vec[6] = '{'{ppr_pkg::OP_INSERT, 16'h0004, 48'd0, 48'd0, 64'h0}, 1'b0, '0};
    vec[7] = '{'{ppr_pkg::OP_SAMPLE, 16'h0, 48'h0, 48'h0, '1}, 1'b0, '0};
    vec[8] = '{'{ppr_pkg::OP_SAMPLE, 16'h0, 48'h0, 48'h0, 64'h0}, 1'b0, '0};
    vec[9] = '{'{ppr_pkg::OP_INSERT, 16'h0005, SMAX - 48'd1, 48'd0, 64'h0}, 1'b0, '0};
    vec[10] = '{'{ppr_pkg::OP_CLEAR, 16'h0, 48'h0, 48'h0, 64'h0}, 1'b1,
                '{ppr_pkg::ST_CLEARED, 16'h0, 48'h0, 16'h0, 48'h0, 48'h0, 7'd0}};
    vec[11] = '{'{ppr_pkg::OP_INSERT, 16'hAAAA, 48'd0, 48'd7, 64'h0}, 1'b0, '0};
    vec[12] = '{'{ppr_pkg::OP_INSERT, 16'h5555, 48'd0, 48'd2, 64'h0}, 1'b0, '0};
    vec[13] = '{'{ppr_pkg::OP_SAMPLE, 16'h0, 48'h0, 48'h0, 64'hFFFF_FFFF_0000_0000},
                1'b0, '0};
    vec[14] = '{'{ppr_pkg::OP_SAMPLE, 16'h0, 48'h0, 48'h0, 64'h0000_0001_FFFF_FFFF},
                1'b0, '0};
    vec[15] = '{'{ppr_pkg::OP_CLEAR, 16'h0, 48'h0, 48'h0, 64'h0}, 1'b0, '0};
    foreach (vec[v]) begin
      send_item(vec[v].it);
      if (vec[v].check_now && expected_q[$] !== vec[v].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: table %p model %p", v, vec[v].want, expected_q[$]);
      end
    end

    // limit settings, extremes included; 0 and 127 exercise the clamps
    limits = '{7'd1, 7'd0, 7'd3, 7'd127, 7'd64, 7'd2};
    for (phase = 0; phase < 6; phase++) begin
      write_limit(limits[phase]);
      if (phase == 2) begin
        send_idle_pct = 68;
        recv_idle_pct = 8;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (idx = 0; idx < 250; idx++)
        send_item(random_item(phase == 3 ? 4000 : 300));
    end

    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("pareto_pool_with_roulette_pick_unit verification clean");
    else
      $display("pareto_pool_with_roulette_pick_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire
